// ===== src/stereo_timestamp_pair_matcher_core_assert.svh =====
// Assertion macros for the stereo timestamp pair matcher.
// Expects clk and rst_n in the scope of each use.
`ifndef STEREO_TIMESTAMP_PAIR_MATCHER_CORE_ASSERT_SVH
`define STEREO_TIMESTAMP_PAIR_MATCHER_CORE_ASSERT_SVH

// check a condition at every clock edge outside reset
`define STPM_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("stpm assertion failed");

// check that a condition implies another at the same edge
`define STPM_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("stpm implication failed");

`endif

// ===== src/stpm_pkg.sv =====
// Shared types and constants of the stereo timestamp pair matcher.
// No dependencies; imported by every module of the block.
package stpm_pkg;

    localparam int TAG_W      = 16;
    localparam int TIME_W     = 48;
    localparam int CNT_W      = 32;
    localparam int SUM_W      = 64;
    localparam int TOL_W      = 20;
    localparam int LIM_W      = 4;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 1;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int TAG_BITS_DEF    = 16;
    localparam int TIME_BITS_DEF   = 48;

    localparam logic [TOL_W-1:0] TOL_RESET = 20'd20000;
    localparam logic [LIM_W-1:0] LIM_RESET = 4'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        CMD_PUSH_LEFT  = 2'd0,
        CMD_PUSH_RIGHT = 2'd1,
        CMD_POP_PAIR   = 2'd2,
        CMD_CLEAR      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_CLEAR
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH_ROOM,
        ST_PUSH_WRITE,
        ST_PUSH_TRIM,
        ST_POP_LOAD,
        ST_POP_DIFF,
        ST_POP_DECIDE,
        ST_POP_MATCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        cmd_t              command;
        logic [TAG_W-1:0]  frame_tag;
        logic [TIME_W-1:0] timestamp_us;
    } in_t;

    typedef struct packed {
        op_t               op;
        logic              right;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] stamp;
    } item_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } fifo_ctl_t;

    typedef struct packed {
        logic              pair_valid;
        logic [TAG_W-1:0]  left_tag;
        logic [TAG_W-1:0]  right_tag;
        logic [TIME_W-1:0] left_time_us;
        logic [TIME_W-1:0] right_time_us;
        logic [TIME_W-1:0] pair_delta_us;
        logic [CNT_W-1:0]  paired_count;
        logic [CNT_W-1:0]  left_dropped_count;
        logic [CNT_W-1:0]  right_dropped_count;
        logic [SUM_W-1:0]  delta_sum_us;
        logic [TIME_W-1:0] delta_max_us;
    } out_t;

endpackage

// ===== src/stpm_front.sv =====
// Front end: accepts command beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on stpm_pkg.
module stpm_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  stpm_pkg::in_t  in_data,
    output logic           item_valid,
    input  logic           item_take,
    output stpm_pkg::item_t item
);
    import stpm_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      classified;
    logic       push, pop;

    always_comb
    begin
        classified.tag   = in_data.frame_tag;
        classified.stamp = in_data.timestamp_us;
        case (in_data.command)
            CMD_PUSH_LEFT:
            begin
                classified.op    = OP_PUSH;
                classified.right = 1'b0;
            end
            CMD_PUSH_RIGHT:
            begin
                classified.op    = OP_PUSH;
                classified.right = 1'b1;
            end
            CMD_POP_PAIR:
            begin
                classified.op    = OP_POP;
                classified.right = 1'b0;
            end
            default:
            begin
                classified.op    = OP_CLEAR;
                classified.right = 1'b0;
            end
        endcase
    end

    assign in_ready   = (count_reg != 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/stpm_side_fifo.sv =====
// Frame queue of one side: circular memory with head pointer, fill count
// and a registered read of the head entry. Depends on stpm_pkg.
module stpm_side_fifo #(
    parameter int DEPTH = stpm_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = stpm_pkg::TAG_BITS_DEF + stpm_pkg::TIME_BITS_DEF,
    parameter int FILL_W = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  stpm_pkg::fifo_ctl_t ctl,
    input  logic [WIDTH-1:0]    wr_data,
    output logic [WIDTH-1:0]    head_data,
    output logic [FILL_W-1:0]   fill
);
    import stpm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0]  mem [DEPTH];
    logic [WIDTH-1:0]  rd_data_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W:0]   tail_sum;
    logic [FILL_W:0]   tail_wrap;
    logic [PTR_W-1:0]  tail_idx;

    always_comb
    begin
        tail_sum  = (FILL_W + 1)'(head_reg) + (FILL_W + 1)'(fill_reg);
        tail_wrap = (tail_sum >= (FILL_W + 1)'(DEPTH)) ? tail_sum - (FILL_W + 1)'(DEPTH)
                                                        : tail_sum;
        tail_idx  = tail_wrap[PTR_W-1:0];
    end

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (ctl.clear)
        begin
            head_next = '0;
            fill_next = '0;
        end
        else if (ctl.push)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push && !ctl.clear)
        begin
            mem[tail_idx] <= wr_data;
        end
        rd_data_reg <= mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    assign head_data = rd_data_reg;
    assign fill      = fill_reg;

endmodule

// ===== src/stpm_back.sv =====
// Back end: sequencer that runs pushes, pair searches and clears on the
// two side queues, keeps the statistics and holds the result register.
// Depends on stpm_pkg.
module stpm_back #(
    parameter int DEPTH     = stpm_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS  = stpm_pkg::TAG_BITS_DEF,
    parameter int TIME_BITS = stpm_pkg::TIME_BITS_DEF,
    parameter int ENTRY_W   = TAG_BITS + TIME_BITS,
    parameter int FILL_W    = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_take,
    input  stpm_pkg::item_t             item,
    input  logic [stpm_pkg::TOL_W-1:0]  tolerance,
    input  logic [stpm_pkg::LIM_W-1:0]  queue_limit,
    output stpm_pkg::fifo_ctl_t         l_ctl,
    output stpm_pkg::fifo_ctl_t         r_ctl,
    output logic [ENTRY_W-1:0]          wr_entry,
    input  logic [ENTRY_W-1:0]          l_head,
    input  logic [FILL_W-1:0]           l_fill,
    input  logic [ENTRY_W-1:0]          r_head,
    input  logic [FILL_W-1:0]           r_fill,
    output logic                        out_valid,
    input  logic                        out_ready,
    output stpm_pkg::out_t              out_data
);
    import stpm_pkg::*;

    localparam int LW = (FILL_W > LIM_W) ? FILL_W : LIM_W;
    localparam int DW = (TIME_BITS > TOL_W) ? TIME_BITS : TOL_W;

    state_t                state_reg, state_next;
    item_t                 cur_reg, cur_next;
    logic                  pv_reg, pv_next;
    logic [TAG_BITS-1:0]   ltag_reg, ltag_next, rtag_reg, rtag_next;
    logic [TIME_BITS-1:0]  lt_reg, lt_next, rt_reg, rt_next;
    logic [TIME_BITS-1:0]  d_reg, d_next;
    logic                  l_older_reg, l_older_next;
    logic [CNT_W-1:0]      pairs_reg, pairs_next;
    logic [CNT_W-1:0]      l_drops_reg, l_drops_next, r_drops_reg, r_drops_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [TIME_BITS-1:0]  peak_reg, peak_next;
    out_t                  out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic [FILL_W-1:0]     sel_fill;
    logic [LW-1:0]         lim;
    logic [TIME_BITS-1:0]  head_lt, head_rt;
    logic [SUM_W:0]        sum_ext;

    always_comb
    begin
        sel_fill = cur_reg.right ? r_fill : l_fill;
        lim      = (LW'(queue_limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(queue_limit);
        head_lt  = l_head[TIME_BITS-1:0];
        head_rt  = r_head[TIME_BITS-1:0];
        sum_ext  = {1'b0, sum_reg} + (SUM_W + 1)'(d_reg);
        wr_entry = {cur_reg.tag[TAG_BITS-1:0], cur_reg.stamp[TIME_BITS-1:0]};
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        pv_next        = pv_reg;
        ltag_next      = ltag_reg;
        rtag_next      = rtag_reg;
        lt_next        = lt_reg;
        rt_next        = rt_reg;
        d_next         = d_reg;
        l_older_next   = l_older_reg;
        pairs_next     = pairs_reg;
        l_drops_next   = l_drops_reg;
        r_drops_next   = r_drops_reg;
        sum_next       = sum_reg;
        peak_next      = peak_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        item_take      = 1'b0;
        l_ctl          = '0;
        r_ctl          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_take = 1'b1;
                    cur_next  = item;
                    pv_next   = 1'b0;
                    ltag_next = '0;
                    rtag_next = '0;
                    lt_next   = '0;
                    rt_next   = '0;
                    d_next    = '0;
                    case (item.op)
                        OP_PUSH:
                        begin
                            state_next = ST_PUSH_ROOM;
                        end
                        OP_POP:
                        begin
                            state_next = ST_POP_LOAD;
                        end
                        OP_CLEAR:
                        begin
                            l_ctl.clear  = 1'b1;
                            r_ctl.clear  = 1'b1;
                            pairs_next   = '0;
                            l_drops_next = '0;
                            r_drops_next = '0;
                            sum_next     = '0;
                            peak_next    = '0;
                            state_next   = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_PUSH_ROOM:
            begin
                if (sel_fill == FILL_W'(DEPTH))
                begin
                    if (cur_reg.right)
                    begin
                        r_ctl.pop    = 1'b1;
                        r_drops_next = (&r_drops_reg) ? r_drops_reg : r_drops_reg + 1'b1;
                    end
                    else
                    begin
                        l_ctl.pop    = 1'b1;
                        l_drops_next = (&l_drops_reg) ? l_drops_reg : l_drops_reg + 1'b1;
                    end
                end
                state_next = ST_PUSH_WRITE;
            end
            ST_PUSH_WRITE:
            begin
                if (cur_reg.right)
                begin
                    r_ctl.push = 1'b1;
                end
                else
                begin
                    l_ctl.push = 1'b1;
                end
                state_next = ST_PUSH_TRIM;
            end
            ST_PUSH_TRIM:
            begin
                if (LW'(sel_fill) > lim)
                begin
                    if (cur_reg.right)
                    begin
                        r_ctl.pop    = 1'b1;
                        r_drops_next = (&r_drops_reg) ? r_drops_reg : r_drops_reg + 1'b1;
                    end
                    else
                    begin
                        l_ctl.pop    = 1'b1;
                        l_drops_next = (&l_drops_reg) ? l_drops_reg : l_drops_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_POP_LOAD:
            begin
                if (l_fill == '0 || r_fill == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_POP_DIFF;
                end
            end
            ST_POP_DIFF:
            begin
                d_next       = (head_lt >= head_rt) ? head_lt - head_rt : head_rt - head_lt;
                l_older_next = (head_lt < head_rt);
                state_next   = ST_POP_DECIDE;
            end
            ST_POP_DECIDE:
            begin
                if (DW'(d_reg) <= DW'(tolerance))
                begin
                    pv_next    = 1'b1;
                    ltag_next  = l_head[ENTRY_W-1:TIME_BITS];
                    rtag_next  = r_head[ENTRY_W-1:TIME_BITS];
                    lt_next    = head_lt;
                    rt_next    = head_rt;
                    l_ctl.pop  = 1'b1;
                    r_ctl.pop  = 1'b1;
                    state_next = ST_POP_MATCH;
                end
                else
                begin
                    if (l_older_reg)
                    begin
                        l_ctl.pop    = 1'b1;
                        l_drops_next = (&l_drops_reg) ? l_drops_reg : l_drops_reg + 1'b1;
                    end
                    else
                    begin
                        r_ctl.pop    = 1'b1;
                        r_drops_next = (&r_drops_reg) ? r_drops_reg : r_drops_reg + 1'b1;
                    end
                    state_next = ST_POP_LOAD;
                end
            end
            ST_POP_MATCH:
            begin
                pairs_next = (&pairs_reg) ? pairs_reg : pairs_reg + 1'b1;
                sum_next   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                peak_next  = (d_reg > peak_reg) ? d_reg : peak_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.pair_valid          = pv_reg;
                    out_next.left_tag            = TAG_W'(ltag_reg);
                    out_next.right_tag           = TAG_W'(rtag_reg);
                    out_next.left_time_us        = TIME_W'(lt_reg);
                    out_next.right_time_us       = TIME_W'(rt_reg);
                    out_next.pair_delta_us       = pv_reg ? TIME_W'(d_reg) : '0;
                    out_next.paired_count        = pairs_reg;
                    out_next.left_dropped_count  = l_drops_reg;
                    out_next.right_dropped_count = r_drops_reg;
                    out_next.delta_sum_us        = sum_reg;
                    out_next.delta_max_us        = TIME_W'(peak_reg);
                    out_valid_next               = 1'b1;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        pv_reg      <= pv_next;
        ltag_reg    <= ltag_next;
        rtag_reg    <= rtag_next;
        lt_reg      <= lt_next;
        rt_reg      <= rt_next;
        d_reg       <= d_next;
        l_older_reg <= l_older_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pairs_reg     <= '0;
            l_drops_reg   <= '0;
            r_drops_reg   <= '0;
            sum_reg       <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pairs_reg     <= pairs_next;
            l_drops_reg   <= l_drops_next;
            r_drops_reg   <= r_drops_next;
            sum_reg       <= sum_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== src/stereo_timestamp_pair_matcher_core.sv =====
// Stereo timestamp pair matcher, top level: front queue, two frame queues,
// back-end sequencer and the configuration registers; uses stpm_pkg and the
// assertion macros. Every command beat gives exactly one result beat, and
// one command is carried out at a time. The front queue registers each
// command; the back-end sequencer runs a push as a room check, a write and a
// trim that drops frames down to the queue limit, a clear in a single step,
// and a pop as a load, a difference and a decision per head comparison (each
// comparison waits for the registered read of the two queue memories). A
// result held on the output does not stop the next command from being taken
// into the front queue while that queue has room.
`include "stereo_timestamp_pair_matcher_core_assert.svh"

module stereo_timestamp_pair_matcher_core #(
    parameter int QUEUE_DEPTH = stpm_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = stpm_pkg::TAG_BITS_DEF,
    parameter int TIME_BITS   = stpm_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  stpm_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output stpm_pkg::out_t                    out_data,
    input  logic                              cfg_wr_en,
    input  logic [stpm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stpm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import stpm_pkg::*;

    localparam int ENTRY_W = TAG_BITS + TIME_BITS;
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);

    logic [TOL_W-1:0]   tolerance_reg, tolerance_next;
    logic [LIM_W-1:0]   limit_reg, limit_next;
    logic               item_valid, item_take;
    item_t              item;
    fifo_ctl_t          l_ctl, r_ctl;
    logic [ENTRY_W-1:0] wr_entry, l_head, r_head;
    logic [FILL_W-1:0]  l_fill, r_fill;
    logic               pair_out;
    logic [TIME_W-1:0]  pair_gap;

    always_comb
    begin
        tolerance_next = tolerance_reg;
        limit_next     = limit_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TOLERANCE:   tolerance_next = cfg_data[TOL_W-1:0];
                CFG_QUEUE_LIMIT: limit_next     = cfg_data[LIM_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOL_RESET;
            limit_reg     <= LIM_RESET;
        end
        else
        begin
            tolerance_reg <= tolerance_next;
            limit_reg     <= limit_next;
        end
    end

    stpm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    stpm_side_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .WIDTH  (ENTRY_W),
        .FILL_W (FILL_W)
    ) u_left_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (l_ctl),
        .wr_data   (wr_entry),
        .head_data (l_head),
        .fill      (l_fill)
    );

    stpm_side_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .WIDTH  (ENTRY_W),
        .FILL_W (FILL_W)
    ) u_right_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (r_ctl),
        .wr_data   (wr_entry),
        .head_data (r_head),
        .fill      (r_fill)
    );

    stpm_back #(
        .DEPTH     (QUEUE_DEPTH),
        .TAG_BITS  (TAG_BITS),
        .TIME_BITS (TIME_BITS),
        .ENTRY_W   (ENTRY_W),
        .FILL_W    (FILL_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_take   (item_take),
        .item        (item),
        .tolerance   (tolerance_reg),
        .queue_limit (limit_reg),
        .l_ctl       (l_ctl),
        .r_ctl       (r_ctl),
        .wr_entry    (wr_entry),
        .l_head      (l_head),
        .l_fill      (l_fill),
        .r_head      (r_head),
        .r_fill      (r_fill),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    assign pair_out = out_valid && out_data.pair_valid;
    assign pair_gap = (out_data.left_time_us >= out_data.right_time_us)
                    ? out_data.left_time_us - out_data.right_time_us
                    : out_data.right_time_us - out_data.left_time_us;

    `STPM_ASSERT(a_fill_bound, (l_fill <= FILL_W'(QUEUE_DEPTH)) && (r_fill <= FILL_W'(QUEUE_DEPTH)))
    `STPM_ASSERT_IMP(a_pair_in_tol, pair_out, out_data.pair_delta_us <= TIME_W'(tolerance_reg))
    `STPM_ASSERT_IMP(a_pair_delta, pair_out, out_data.pair_delta_us == pair_gap)
    `STPM_ASSERT_IMP(a_peak_covers, pair_out, out_data.delta_max_us >= out_data.pair_delta_us)

endmodule
